@@ sv/rgbcs_pkg.sv @@
`timescale 1ns / 1ps

package rgbcs_pkg;

   localparam int PERIOD_W = 16;
   localparam int LEVEL_W  = 8;
   localparam int CLASS_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;

   // register reset values
   localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST = 16'd20;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST = 16'd200;
   localparam logic [LEVEL_W-1:0]  ORANGE_RED_LIMIT_RST = 8'd20;
   localparam logic [LEVEL_W-1:0]  BLUE_GREEN_FLOOR_RST = 8'd190;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MAX    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORANGE_LIM  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_FLOOR  = 3'd7;

   // class codes
   localparam logic [CLASS_W-1:0] CLS_BLACK  = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_BLUE   = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_GREEN  = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_ORANGE = 2'd3;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } channel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_MAP,
      ST_DIV,
      ST_STORE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MAP_ZERO,
      MAP_FULL,
      MAP_DIVIDE
   } map_kind_type;

endpackage

@@ sv/rgbcs_div.sv @@
`timescale 1ns / 1ps

module rgbcs_div #(
   parameter int DIVIDEND_W = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIVIDEND_W-1:0]             dividend,
   input  logic [rgbcs_pkg::PERIOD_W-1:0]    divisor,
   output logic                              done,
   output logic [DIVIDEND_W-1:0]             quotient
);
   import rgbcs_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [PERIOD_W-1:0]   rem_ff;
   logic [PERIOD_W-1:0]   div_ff;
   logic [DIVIDEND_W-1:0] quo_ff;

   logic [PERIOD_W:0]     trial;
   logic [PERIOD_W:0]     trial_diff;
   logic                  fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      fits       = (trial >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/rgb_colour_sensor_classifier_core.sv @@
`timescale 1ns / 1ps

// Sequence: a sample that does not close a group is accepted while the sequencer is idle. A closing sample
// stalls the input while the shared serial divider forms the average (AVG), the level is mapped (MAP)
// and, unless the level needs no division, divided (DIV), and the level is stored (STORE).
// The blue group then loads the result register (EMIT) before rsp_valid rises, and waits
// there while an earlier result is still stalled.
// Reset: synchronous, active high; clears sequencer, sums, held levels and register defaults.
module rgb_colour_sensor_classifier_core #(
   parameter int SAMPLES_PER_CHANNEL = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rgbcs_pkg::PERIOD_W-1:0]       req_sample_period,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rgbcs_pkg::LEVEL_W-1:0]        rsp_red_level,
   output logic [rgbcs_pkg::LEVEL_W-1:0]        rsp_green_level,
   output logic [rgbcs_pkg::LEVEL_W-1:0]        rsp_blue_level,
   output logic [rgbcs_pkg::CLASS_W-1:0]        rsp_colour_class,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rgbcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rgbcs_pkg::PERIOD_W-1:0]       csr_wdata
);
   import rgbcs_pkg::*;

   localparam int SUM_W  = PERIOD_W + $clog2(SAMPLES_PER_CHANNEL);
   localparam int PROD_W = PERIOD_W + LEVEL_W;
   localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int POS_W  = (SAMPLES_PER_CHANNEL > 1) ? $clog2(SAMPLES_PER_CHANNEL) : 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLES_PER_CHANNEL - 1);
   localparam logic [PERIOD_W-1:0] GROUP_SIZE = PERIOD_W'(SAMPLES_PER_CHANNEL);

   // configuration registers
   logic [PERIOD_W-1:0] red_min_ff, red_max_ff;
   logic [PERIOD_W-1:0] green_min_ff, green_max_ff;
   logic [PERIOD_W-1:0] blue_min_ff, blue_max_ff;
   logic [LEVEL_W-1:0]  orange_lim_ff, blue_floor_ff;

   state_type           state_ff, state_in;
   channel_type         channel_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [PERIOD_W-1:0] avg_ff;
   logic [LEVEL_W-1:0]  lvl_ff;
   logic [LEVEL_W-1:0]  held_red_ff, held_green_ff;

   logic                rsp_valid_ff;
   logic [LEVEL_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [CLASS_W-1:0]  rsp_class_ff;

   logic                req_fire;
   logic                group_end;
   logic [SUM_W-1:0]    sum_in;
   logic                out_free;

   logic [PERIOD_W-1:0] map_lo, map_hi, map_span, map_diff;
   logic [PROD_W-1:0]   map_prod;
   map_kind_type        map_kind;

   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [PERIOD_W-1:0] div_divisor;
   logic                div_done;
   logic [DIV_W-1:0]    div_quo;
   logic [LEVEL_W-1:0]  div_level;
   logic [CLASS_W-1:0]  cls;

   rgbcs_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign group_end = (pos_ff == LAST_POS);
   assign sum_in    = sum_ff + SUM_W'(req_sample_period);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // mapping operands for the channel being closed
   always_comb begin
      unique case (channel_ff)
         CH_RED: begin
            map_lo = red_min_ff;
            map_hi = red_max_ff;
         end
         CH_GREEN: begin
            map_lo = green_min_ff;
            map_hi = green_max_ff;
         end
         CH_BLUE: begin
            map_lo = blue_min_ff;
            map_hi = blue_max_ff;
         end
         default: begin
            map_lo = blue_min_ff;
            map_hi = blue_max_ff;
         end
      endcase
      map_span = map_hi - map_lo;
      map_diff = avg_ff - map_lo;
      map_prod = PROD_W'(map_diff) * PROD_W'(LEVEL_MAX);
      priority if (avg_ff == '0 || map_hi <= map_lo) begin
         map_kind = MAP_ZERO;
      end else if (avg_ff <= map_lo) begin
         map_kind = MAP_FULL;
      end else begin
         map_kind = MAP_DIVIDE;
      end
   end

   // level from the scaled quotient, clamped at zero
   assign div_level = (div_quo >= DIV_W'(LEVEL_MAX)) ? LEVEL_MIN
                    : LEVEL_MAX - div_quo[LEVEL_W-1:0];

   always_comb begin
      priority if (held_red_ff < lvl_ff && held_red_ff < held_green_ff
                   && held_red_ff < orange_lim_ff) begin
         cls = CLS_ORANGE;
      end else if (lvl_ff < held_red_ff && lvl_ff < held_green_ff
                   && held_green_ff > blue_floor_ff) begin
         cls = CLS_BLUE;
      end else if (held_green_ff < held_red_ff && held_green_ff < lvl_ff) begin
         cls = CLS_GREEN;
      end else begin
         cls = CLS_BLACK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && group_end) state_in = ST_AVG;
         ST_AVG:   if (div_done) state_in = ST_MAP;
         ST_MAP:   state_in = (map_kind == MAP_DIVIDE) ? ST_DIV : ST_STORE;
         ST_DIV:   if (div_done) state_in = ST_STORE;
         ST_STORE: state_in = (channel_ff == CH_BLUE) ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // divider control
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_W'(sum_in);
      div_divisor  = GROUP_SIZE;
      unique case (state_ff)
         ST_IDLE: begin
            div_start = req_fire && group_end;
         end
         ST_MAP: begin
            div_start    = (map_kind == MAP_DIVIDE);
            div_dividend = DIV_W'(map_prod);
            div_divisor  = map_span;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_min_ff    <= PERIOD_MIN_RST;
         red_max_ff    <= PERIOD_MAX_RST;
         green_min_ff  <= PERIOD_MIN_RST;
         green_max_ff  <= PERIOD_MAX_RST;
         blue_min_ff   <= PERIOD_MIN_RST;
         blue_max_ff   <= PERIOD_MAX_RST;
         orange_lim_ff <= ORANGE_RED_LIMIT_RST;
         blue_floor_ff <= BLUE_GREEN_FLOOR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RED_MIN:    red_min_ff    <= csr_wdata;
            CSR_RED_MAX:    red_max_ff    <= csr_wdata;
            CSR_GREEN_MIN:  green_min_ff  <= csr_wdata;
            CSR_GREEN_MAX:  green_max_ff  <= csr_wdata;
            CSR_BLUE_MIN:   blue_min_ff   <= csr_wdata;
            CSR_BLUE_MAX:   blue_max_ff   <= csr_wdata;
            CSR_ORANGE_LIM: orange_lim_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_BLUE_FLOOR: blue_floor_ff <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         channel_ff    <= CH_RED;
         pos_ff        <= '0;
         sum_ff        <= '0;
         held_red_ff   <= '0;
         held_green_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (req_fire) begin
            if (group_end) begin
               pos_ff <= '0;
               sum_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
               sum_ff <= sum_in;
            end
         end

         if (state_ff == ST_STORE) begin
            unique case (channel_ff)
               CH_RED: begin
                  held_red_ff <= lvl_ff;
                  channel_ff  <= CH_GREEN;
               end
               CH_GREEN: begin
                  held_green_ff <= lvl_ff;
                  channel_ff    <= CH_BLUE;
               end
               default: ;
            endcase
         end

         // load a new result when the slot frees, else drop one once taken
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
            channel_ff   <= CH_RED;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_AVG && div_done) begin
         avg_ff <= div_quo[PERIOD_W-1:0];
      end
      if (state_ff == ST_MAP) begin
         lvl_ff <= (map_kind == MAP_FULL) ? LEVEL_MAX : LEVEL_MIN;
      end else if (state_ff == ST_DIV && div_done) begin
         lvl_ff <= div_level;
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_red_ff   <= held_red_ff;
         rsp_green_ff <= held_green_ff;
         rsp_blue_ff  <= lvl_ff;
         rsp_class_ff <= cls;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_level    = rsp_red_ff;
   assign rsp_green_level  = rsp_green_ff;
   assign rsp_blue_level   = rsp_blue_ff;
   assign rsp_colour_class = rsp_class_ff;

endmodule

@@ sv/rgbcs_checker.sv @@
`timescale 1ns / 1ps

module rgbcs_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_stall,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [rgbcs_pkg::LEVEL_W-1:0]        rsp_red_level,
   input  logic [rgbcs_pkg::LEVEL_W-1:0]        rsp_green_level,
   input  logic [rgbcs_pkg::LEVEL_W-1:0]        rsp_blue_level,
   input  logic [rgbcs_pkg::CLASS_W-1:0]        rsp_colour_class
);
   import rgbcs_pkg::*;

   // a result is never pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_level)
         && $stable(rsp_green_level) && $stable(rsp_blue_level)
         && $stable(rsp_colour_class))
      else $error("stalled result changed");

   // a new result is only produced while the sequencer is busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while input side was idle");

   a_orange_lowest_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_colour_class == CLS_ORANGE |->
         rsp_red_level < rsp_green_level && rsp_red_level < rsp_blue_level)
      else $error("orange class without lowest red level");

   a_blue_lowest_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_colour_class == CLS_BLUE |->
         rsp_blue_level < rsp_red_level && rsp_blue_level < rsp_green_level)
      else $error("blue class without lowest blue level");

endmodule

bind rgb_colour_sensor_classifier_core rgbcs_checker u_rgbcs_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import rgbcs_pkg::*;

   localparam int GROUP_LEN     = 5;
   localparam int PHASE_ITEMS   = 200;
   localparam int PHASES        = 8;
   localparam int HOLD_CYCLES   = 2000;
   localparam int SETTLE_CYCLES = 80;
   localparam int DRAIN_LIMIT   = 20000;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [CLASS_W-1:0] cls;
   } reading_type;

   typedef enum {
      SET_RESET_VALUES,
      SET_FULL_SPAN,
      SET_EMPTY_SPAN,
      SET_RANDOM,
      SET_TOP_END
   } setting_kind_type;

   class reading_predictor_type;
      logic [PERIOD_W-1:0] period_lo[3];
      logic [PERIOD_W-1:0] period_hi[3];
      logic [LEVEL_W-1:0]  orange_limit;
      logic [LEVEL_W-1:0]  blue_floor;
      int unsigned         pos_in_round;
      logic [18:0]         group_sum;
      logic [LEVEL_W-1:0]  red_held;
      logic [LEVEL_W-1:0]  green_held;
      reading_type         pending_readings[$];
      int                  errors;
      int                  samples;
      int                  readings;
      int                  class_seen[4];

      function new();
         for (int c = 0; c < 3; c++) begin
            period_lo[c] = PERIOD_MIN_RST;
            period_hi[c] = PERIOD_MAX_RST;
         end
         orange_limit = ORANGE_RED_LIMIT_RST;
         blue_floor   = BLUE_GREEN_FLOOR_RST;
         pos_in_round = 0;
         group_sum    = '0;
         red_held     = '0;
         green_held   = '0;
         errors       = 0;
         samples      = 0;
         readings     = 0;
         class_seen   = '{0, 0, 0, 0};
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
         case (idx)
            CSR_RED_MIN:    period_lo[CH_RED]   = data;
            CSR_RED_MAX:    period_hi[CH_RED]   = data;
            CSR_GREEN_MIN:  period_lo[CH_GREEN] = data;
            CSR_GREEN_MAX:  period_hi[CH_GREEN] = data;
            CSR_BLUE_MIN:   period_lo[CH_BLUE]  = data;
            CSR_BLUE_MAX:   period_hi[CH_BLUE]  = data;
            CSR_ORANGE_LIM: orange_limit = data[LEVEL_W-1:0];
            CSR_BLUE_FLOOR: blue_floor   = data[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      function channel_type channel_now();
         return channel_type'(pos_in_round / GROUP_LEN);
      endfunction

      function int unsigned slot_now();
         return pos_in_round % GROUP_LEN;
      endfunction

      // Inverse map of the group average; the period at lo gives full scale.
      function logic [LEVEL_W-1:0] scale_level(logic [PERIOD_W-1:0] avg,
                                               logic [PERIOD_W-1:0] lo,
                                               logic [PERIOD_W-1:0] hi);
         longint a, l, h, v;
         if (avg == 0 || hi <= lo)
            return LEVEL_MIN;
         a = avg;
         l = lo;
         h = hi;
         v = ((a - l) * -255) / (h - l) + 255;
         if (v < 0)
            return LEVEL_MIN;
         if (v > 255)
            return LEVEL_MAX;
         return v[LEVEL_W-1:0];
      endfunction

      function logic [CLASS_W-1:0] classify(logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
                                            logic [LEVEL_W-1:0] b);
         if (r < b && r < g && r < orange_limit)
            return CLS_ORANGE;
         if (b < r && b < g && g > blue_floor)
            return CLS_BLUE;
         if (g < r && g < b)
            return CLS_GREEN;
         return CLS_BLACK;
      endfunction

      function void note_sample(logic [PERIOD_W-1:0] period);
         channel_type        ch;
         int unsigned        slot;
         logic [LEVEL_W-1:0] lvl;
         logic [18:0]        avg;
         reading_type        rd;
         samples++;
         group_sum += period;
         ch   = channel_now();
         slot = slot_now();
         pos_in_round++;
         if (slot != GROUP_LEN - 1)
            return;
         avg = 19'(group_sum / GROUP_LEN);
         lvl = scale_level(avg[PERIOD_W-1:0], period_lo[ch], period_hi[ch]);
         group_sum = '0;
         case (ch)
            CH_RED:   red_held = lvl;
            CH_GREEN: green_held = lvl;
            default: begin
               pos_in_round = 0;
               rd.red   = red_held;
               rd.green = green_held;
               rd.blue  = lvl;
               rd.cls   = classify(red_held, green_held, lvl);
               pending_readings.push_back(rd);
            end
         endcase
      endfunction

      function void check_result(reading_type got);
         reading_type exp;
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: red %0d green %0d blue %0d class %0d",
                   got.red, got.green, got.blue, got.cls);
            errors++;
            return;
         end
         exp = pending_readings.pop_front();
         readings++;
         class_seen[exp.cls]++;
         if (got.red !== exp.red) begin
            $error("red_level: expected %0d, got %0d", exp.red, got.red);
            errors++;
         end
         if (got.green !== exp.green) begin
            $error("green_level: expected %0d, got %0d", exp.green, got.green);
            errors++;
         end
         if (got.blue !== exp.blue) begin
            $error("blue_level: expected %0d, got %0d", exp.blue, got.blue);
            errors++;
         end
         if (got.cls !== exp.cls) begin
            $error("colour_class: expected %0d, got %0d", exp.cls, got.cls);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_stall;
   logic [PERIOD_W-1:0]  req_sample_period;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [LEVEL_W-1:0]   rsp_red_level;
   logic [LEVEL_W-1:0]   rsp_green_level;
   logic [LEVEL_W-1:0]   rsp_blue_level;
   logic [CLASS_W-1:0]   rsp_colour_class;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PERIOD_W-1:0]  csr_wdata;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_armed = 1'b0;
   int settings_applied = 0;

   setting_kind_type setting_seq[PHASES] = '{SET_FULL_SPAN, SET_RANDOM, SET_EMPTY_SPAN,
      SET_RANDOM, SET_TOP_END, SET_RANDOM, SET_RESET_VALUES, SET_RANDOM};

   reading_predictor_type predictor = new();

   rgb_colour_sensor_classifier_core #(
      .SAMPLES_PER_CHANNEL(GROUP_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_period(req_sample_period),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_level(rsp_red_level),
      .rsp_green_level(rsp_green_level),
      .rsp_blue_level(rsp_blue_level),
      .rsp_colour_class(rsp_colour_class),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off to back up the input.
   initial begin : rsp_side
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      reading_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.red   = rsp_red_level;
         got.green = rsp_green_level;
         got.blue  = rsp_blue_level;
         got.cls   = rsp_colour_class;
         predictor.check_result(got);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_sample(input logic [PERIOD_W-1:0] period);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_period <= period;
      do @(posedge clock); while (req_stall);
      predictor.note_sample(period);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      predictor.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic apply_setting(input setting_kind_type kind);
      logic [PERIOD_W-1:0] lo[3];
      logic [PERIOD_W-1:0] hi[3];
      logic [PERIOD_W-1:0] lim;
      logic [PERIOD_W-1:0] flo;
      case (kind)
         SET_RESET_VALUES: begin
            lo  = '{PERIOD_MIN_RST, PERIOD_MIN_RST, PERIOD_MIN_RST};
            hi  = '{PERIOD_MAX_RST, PERIOD_MAX_RST, PERIOD_MAX_RST};
            lim = ORANGE_RED_LIMIT_RST;
            flo = BLUE_GREEN_FLOOR_RST;
         end
         SET_FULL_SPAN: begin
            lo  = '{16'd0, 16'd0, 16'd0};
            hi  = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
            // upper byte must be dropped by the 8-bit registers
            lim = 16'hFFFF;
            flo = 16'hFF00;
         end
         SET_EMPTY_SPAN: begin
            lo  = '{16'd300, 16'd1000, 16'd50};
            hi  = '{16'd300, 16'd400, 16'd5000};
            lim = 16'd128;
            flo = 16'd100;
         end
         SET_TOP_END: begin
            lo  = '{16'hFFFE, 16'hFFFE, 16'hFFFE};
            hi  = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
            lim = 16'h0000;
            flo = 16'h00FF;
         end
         default: begin
            for (int c = 0; c < 3; c++) begin
               lo[c] = PERIOD_W'($urandom_range(3000, 0));
               hi[c] = lo[c] + PERIOD_W'($urandom_range(4000, 1));
            end
            lim = PERIOD_W'($urandom_range(65535, 0));
            flo = PERIOD_W'($urandom_range(65535, 0));
         end
      endcase
      csr_write(CSR_RED_MIN, lo[CH_RED]);
      csr_write(CSR_RED_MAX, hi[CH_RED]);
      csr_write(CSR_GREEN_MIN, lo[CH_GREEN]);
      csr_write(CSR_GREEN_MAX, hi[CH_GREEN]);
      csr_write(CSR_BLUE_MIN, lo[CH_BLUE]);
      csr_write(CSR_BLUE_MAX, hi[CH_BLUE]);
      csr_write(CSR_ORANGE_LIM, lim);
      csr_write(CSR_BLUE_FLOOR, flo);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Wait for every expected reading, then let a group still in the divider finish.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (predictor.pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      channel_type         ch;
      int                  kind;
      int                  centre;
      int                  val;
      logic [PERIOD_W-1:0] lo;
      logic [PERIOD_W-1:0] hi;
      req_valid         = 1'b0;
      req_sample_period = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_RED_MIN;
      csr_wdata         = '0;
      kind              = 0;
      centre            = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // timeout on red, green past its max, blue at its min
      repeat (GROUP_LEN) send_sample('0);
      repeat (GROUP_LEN) send_sample('1);
      repeat (GROUP_LEN) send_sample(PERIOD_MIN_RST);
      // red at its max, green mid-span, blue below its min
      repeat (GROUP_LEN) send_sample(PERIOD_MAX_RST);
      repeat (GROUP_LEN) send_sample(16'd110);
      repeat (GROUP_LEN) send_sample(16'd1);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         apply_setting(setting_seq[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         if (ph == 5)
            hold_armed = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (predictor.slot_now() == 0) begin
               ch = predictor.channel_now();
               lo = predictor.period_lo[ch];
               hi = predictor.period_hi[ch];
               kind = $urandom_range(15, 0);
               case (kind)
                  0: centre = 0;
                  1: centre = -1;
                  2: centre = lo / 2;
                  3: centre = hi + (65535 - hi) / 2;
                  default:
                     centre = (hi > lo) ? lo + $urandom_range(hi - lo, 0)
                                        : $urandom_range(65535, 0);
               endcase
            end
            // timeout group: zeros and ones only; full-random group: any 16-bit value
            if (kind == 0)
               val = $urandom_range(1, 0);
            else if (centre < 0)
               val = $urandom_range(65535, 0);
            else
               val = centre + $urandom_range(6, 0) - 3;
            if (val < 0)
               val = 0;
            if (val > 65535)
               val = 65535;
            send_sample(val[PERIOD_W-1:0]);
         end
      end
      drain();

      if (predictor.pending_readings.size() != 0) begin
         $error("%0d readings never arrived", predictor.pending_readings.size());
         predictor.errors++;
      end
      $display("tb: %0d samples over %0d register settings, %0d readings checked",
               predictor.samples, settings_applied, predictor.readings);
      $display("tb: classes black %0d, blue %0d, green %0d, orange %0d",
               predictor.class_seen[CLS_BLACK], predictor.class_seen[CLS_BLUE],
               predictor.class_seen[CLS_GREEN], predictor.class_seen[CLS_ORANGE]);
      if (predictor.errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
sv/rgbcs_pkg.sv
sv/rgbcs_div.sv
sv/rgb_colour_sensor_classifier_core.sv
sv/rgbcs_checker.sv
tb/tb.sv
